@@ rtl/core/fspv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fspv_pkg: shared types and constants of the sine PWM phase voltage block
// Field widths, fixed-point constants, register map and the config bundle.
// ----------------------------------------------------------------------------
package fspv_pkg;

	// default build of the quarter-wave table
	localparam int unsigned SINE_DEPTH_DEF = 256;
	localparam int unsigned TRIG_FRAC_DEF  = 15;

	// field widths
	localparam int unsigned VOLT_W      = 16;
	localparam int unsigned ANGLE_W     = 16;
	localparam int unsigned QUAD_FRAC_W = 14;
	localparam int unsigned PHASE_W     = 18;
	localparam int unsigned U_W         = 19;
	localparam int unsigned LIMIT_W     = 15;

	localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

	// sqrt(3)/2 in Q17
	localparam int unsigned SQRT3_FRAC_W = 17;
	localparam logic [SQRT3_FRAC_W-1:0] SQRT3_HALF_Q17 = 17'd113512;

	// APB register map
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic REG_LIMIT = 1'b0;
	localparam logic REG_MODE  = 1'b1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 15'd12288;
	localparam logic               CENTERED_RESET = 1'b1;

	typedef struct packed {
		logic [LIMIT_W-1:0] supply_limit;
		logic               centered_mode;
	} cfg_t;

endpackage
`default_nettype wire

@@ rtl/core/fspv_trig.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fspv_trig: sine and cosine lookup
// Stage 1 folds the angle into a quarter-wave index, stage 2 reads the
// table and applies the sign of the quadrant.
// ----------------------------------------------------------------------------
module fspv_trig #(
	parameter int unsigned SINE_TABLE_DEPTH = fspv_pkg::SINE_DEPTH_DEF,
	parameter int unsigned TRIG_FRAC_BITS   = fspv_pkg::TRIG_FRAC_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                up_valid,
	output logic                                up_ready,
	input  logic signed [fspv_pkg::VOLT_W-1:0]  volt_q,
	input  logic signed [fspv_pkg::VOLT_W-1:0]  volt_d,
	input  logic        [fspv_pkg::ANGLE_W-1:0] rotor_angle,
	input  logic                                reverse_dir,
	output logic                                dn_valid,
	input  logic                                dn_ready,
	output logic signed [TRIG_FRAC_BITS+1:0]    sin_val,
	output logic signed [TRIG_FRAC_BITS+1:0]    cos_val,
	output logic signed [fspv_pkg::VOLT_W-1:0]  vq_out,
	output logic signed [fspv_pkg::VOLT_W-1:0]  vd_out,
	output logic                                rev_out
);
	import fspv_pkg::*;

	localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int unsigned PROD_W = QUAD_FRAC_W + IDX_W + 1;
	localparam int unsigned TRIG_W = TRIG_FRAC_BITS + 2;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

	// sin(pi/2 * i / depth) by a nested Taylor series in Q30, rounded to the table format
	function automatic logic [TRIG_FRAC_BITS:0] quarter_entry(input int unsigned i);
		logic [63:0] x, x2, t, s, e;
		x  = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 156;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
		s  = (x * t) >> 30;
		e  = (s + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
		if (e > (64'd1 << TRIG_FRAC_BITS)) begin
			e = 64'd1 << TRIG_FRAC_BITS;
		end
		return e[TRIG_FRAC_BITS:0];
	endfunction

	// returns {negate, table index}
	function automatic logic [IDX_W:0] fold_index(input logic [ANGLE_W-1:0] ang);
		logic [PROD_W-1:0] prod;
		logic [IDX_W-1:0]  idx;
		prod = PROD_W'(ang[QUAD_FRAC_W-1:0]) * PROD_W'(SINE_TABLE_DEPTH)
			+ (PROD_W'(1) << (QUAD_FRAC_W - 1));
		idx  = prod[QUAD_FRAC_W +: IDX_W];
		// odd quadrants run the table backwards
		if (ang[QUAD_FRAC_W]) begin
			idx = IDX_W'(SINE_TABLE_DEPTH) - idx;
		end
		return {ang[QUAD_FRAC_W+1], idx};
	endfunction

	logic [TRIG_FRAC_BITS:0] sin_rom [SINE_TABLE_DEPTH+1];

	for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
		assign sin_rom[g] = quarter_entry(g);
	end

	logic                    adv_s1, adv_s2;
	logic                    valid_s1, valid_s2;
	logic [ANGLE_W-1:0]      cos_angle;
	logic [IDX_W:0]          sin_fold, cos_fold;
	logic [IDX_W-1:0]        sin_idx_s1, cos_idx_s1;
	logic                    sin_neg_s1, cos_neg_s1;
	logic signed [VOLT_W-1:0] vq_s1, vd_s1, vq_s2, vd_s2;
	logic                    rev_s1, rev_s2;
	logic signed [TRIG_W-1:0] sin_mag, cos_mag, sin_s2, cos_s2;

	assign adv_s2   = !valid_s2 || dn_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign up_ready = adv_s1;

	assign cos_angle = rotor_angle + QUARTER_TURN;
	assign sin_fold  = fold_index(rotor_angle);
	assign cos_fold  = fold_index(cos_angle);
	assign sin_mag   = TRIG_W'(sin_rom[sin_idx_s1]);
	assign cos_mag   = TRIG_W'(sin_rom[cos_idx_s1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= up_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && up_valid) begin
			sin_idx_s1 <= sin_fold[IDX_W-1:0];
			sin_neg_s1 <= sin_fold[IDX_W];
			cos_idx_s1 <= cos_fold[IDX_W-1:0];
			cos_neg_s1 <= cos_fold[IDX_W];
			vq_s1      <= volt_q;
			vd_s1      <= volt_d;
			rev_s1     <= reverse_dir;
		end
		if (adv_s2 && valid_s1) begin
			sin_s2 <= sin_neg_s1 ? -sin_mag : sin_mag;
			cos_s2 <= cos_neg_s1 ? -cos_mag : cos_mag;
			vq_s2  <= vq_s1;
			vd_s2  <= vd_s1;
			rev_s2 <= rev_s1;
		end
	end

	assign dn_valid = valid_s2;
	assign sin_val  = sin_s2;
	assign cos_val  = cos_s2;
	assign vq_out   = vq_s2;
	assign vd_out   = vd_s2;
	assign rev_out  = rev_s2;

endmodule
`default_nettype wire

@@ rtl/core/fspv_park.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fspv_park: inverse Park transform
// Stage 1 forms the four products, stage 2 sums them into alpha and beta.
// ----------------------------------------------------------------------------
module fspv_park #(
	parameter int unsigned TRIG_FRAC_BITS = fspv_pkg::TRIG_FRAC_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               up_valid,
	output logic                               up_ready,
	input  logic signed [TRIG_FRAC_BITS+1:0]   sin_val,
	input  logic signed [TRIG_FRAC_BITS+1:0]   cos_val,
	input  logic signed [fspv_pkg::VOLT_W-1:0] volt_q,
	input  logic signed [fspv_pkg::VOLT_W-1:0] volt_d,
	input  logic                               rev_in,
	output logic                               dn_valid,
	input  logic                               dn_ready,
	output logic signed [TRIG_FRAC_BITS+18:0]  alpha,
	output logic signed [TRIG_FRAC_BITS+18:0]  beta,
	output logic                               rev_out
);
	import fspv_pkg::*;

	localparam int unsigned PROD_W = TRIG_FRAC_BITS + 2 + VOLT_W;
	localparam int unsigned SUM_W  = PROD_W + 1;

	logic                    adv_s1, adv_s2;
	logic                    valid_s1, valid_s2;
	logic signed [PROD_W-1:0] p_cd_s1, p_sq_s1, p_sd_s1, p_cq_s1;
	logic signed [SUM_W-1:0]  alpha_s2, beta_s2;
	logic                    rev_s1, rev_s2;

	assign adv_s2   = !valid_s2 || dn_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign up_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= up_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && up_valid) begin
			p_cd_s1 <= PROD_W'(cos_val) * PROD_W'(volt_d);
			p_sq_s1 <= PROD_W'(sin_val) * PROD_W'(volt_q);
			p_sd_s1 <= PROD_W'(sin_val) * PROD_W'(volt_d);
			p_cq_s1 <= PROD_W'(cos_val) * PROD_W'(volt_q);
			rev_s1  <= rev_in;
		end
		if (adv_s2 && valid_s1) begin
			alpha_s2 <= SUM_W'(p_cd_s1) - SUM_W'(p_sq_s1);
			beta_s2  <= SUM_W'(p_sd_s1) + SUM_W'(p_cq_s1);
			rev_s2   <= rev_s1;
		end
	end

	assign dn_valid = valid_s2;
	assign alpha    = alpha_s2;
	assign beta     = beta_s2;
	assign rev_out  = rev_s2;

endmodule
`default_nettype wire

@@ rtl/core/fspv_clarke.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fspv_clarke: inverse Clarke transform
// Stage 1 scales alpha and beta, stage 2 combines them into three phases
// and rounds half up to Q10.
// ----------------------------------------------------------------------------
module fspv_clarke #(
	parameter int unsigned TRIG_FRAC_BITS = fspv_pkg::TRIG_FRAC_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             up_valid,
	output logic                             up_ready,
	input  logic signed [TRIG_FRAC_BITS+18:0] alpha,
	input  logic signed [TRIG_FRAC_BITS+18:0] beta,
	input  logic                             rev_in,
	output logic                             dn_valid,
	input  logic                             dn_ready,
	output logic signed [fspv_pkg::U_W-1:0]  u_a,
	output logic signed [fspv_pkg::U_W-1:0]  u_b,
	output logic signed [fspv_pkg::U_W-1:0]  u_c,
	output logic                             rev_out
);
	import fspv_pkg::*;

	localparam int unsigned CL_W = TRIG_FRAC_BITS + 38;
	localparam int unsigned SH   = TRIG_FRAC_BITS + SQRT3_FRAC_W;

	function automatic logic signed [U_W-1:0] round_q10(input logic signed [CL_W-1:0] v);
		logic [CL_W-1:0] r;
		r = v + (CL_W'(1) << (SH - 1));
		return r[SH +: U_W];
	endfunction

	logic                   adv_s1, adv_s2;
	logic                   valid_s1, valid_s2;
	logic signed [CL_W-1:0] a_term_s1, b_term_s1;
	logic signed [U_W-1:0]  ua_s2, ub_s2, uc_s2;
	logic                   rev_s1, rev_s2;

	assign adv_s2   = !valid_s2 || dn_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign up_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= up_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && up_valid) begin
			// alpha/2 term, carried at the Q17 scale of sqrt(3)/2
			a_term_s1 <= CL_W'(alpha) <<< (SQRT3_FRAC_W - 1);
			b_term_s1 <= CL_W'(beta) * CL_W'($signed({1'b0, SQRT3_HALF_Q17}));
			rev_s1    <= rev_in;
		end
		if (adv_s2 && valid_s1) begin
			ua_s2  <= round_q10(a_term_s1 <<< 1);
			ub_s2  <= round_q10(b_term_s1 - a_term_s1);
			uc_s2  <= round_q10(-a_term_s1 - b_term_s1);
			rev_s2 <= rev_s1;
		end
	end

	assign dn_valid = valid_s2;
	assign u_a      = ua_s2;
	assign u_b      = ub_s2;
	assign u_c      = uc_s2;
	assign rev_out  = rev_s2;

endmodule
`default_nettype wire

@@ rtl/core/fspv_offset.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fspv_offset: phase offset and direction swap
// Stage 1 finds the largest and smallest phase, stage 2 applies the midpoint
// clamp or the minimum shift, swaps b and c on reverse, and holds the result.
// ----------------------------------------------------------------------------
module fspv_offset (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fspv_pkg::cfg_t                     cfg,
	input  logic                               up_valid,
	output logic                               up_ready,
	input  logic signed [fspv_pkg::U_W-1:0]    u_a,
	input  logic signed [fspv_pkg::U_W-1:0]    u_b,
	input  logic signed [fspv_pkg::U_W-1:0]    u_c,
	input  logic                               rev_in,
	output logic                               dn_valid,
	input  logic                               dn_ready,
	output logic signed [fspv_pkg::PHASE_W-1:0] phase_a,
	output logic signed [fspv_pkg::PHASE_W-1:0] phase_b,
	output logic signed [fspv_pkg::PHASE_W-1:0] phase_c
);
	import fspv_pkg::*;

	localparam int unsigned OFS_W = U_W + 2;

	function automatic logic signed [PHASE_W-1:0] shift_phase(
		input logic signed [U_W-1:0] u,
		input logic signed [U_W-1:0] mx,
		input logic signed [U_W-1:0] mn,
		input cfg_t                  c
	);
		logic [OFS_W-1:0] t;
		logic [U_W-1:0]   d;
		t = (OFS_W'(u) <<< 1) + OFS_W'(c.supply_limit) - OFS_W'(mx) - OFS_W'(mn) + OFS_W'(1);
		d = u - mn;
		// halve with rounding half up
		return c.centered_mode ? t[1 +: PHASE_W] : d[PHASE_W-1:0];
	endfunction

	logic                   adv_s1, adv_s2;
	logic                   valid_s1, valid_s2;
	logic signed [U_W-1:0]  mn_ab, mx_ab, mn_next, mx_next;
	logic signed [U_W-1:0]  ua_s1, ub_s1, uc_s1, mn_s1, mx_s1;
	logic                   rev_s1;
	logic signed [PHASE_W-1:0] pa, pb, pc;
	logic signed [PHASE_W-1:0] pa_s2, pb_s2, pc_s2;

	assign adv_s2   = !valid_s2 || dn_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign up_ready = adv_s1;

	always_comb begin
		mn_ab   = (u_b < u_a) ? u_b : u_a;
		mx_ab   = (u_b > u_a) ? u_b : u_a;
		mn_next = (u_c < mn_ab) ? u_c : mn_ab;
		mx_next = (u_c > mx_ab) ? u_c : mx_ab;
	end

	assign pa = shift_phase(ua_s1, mx_s1, mn_s1, cfg);
	assign pb = shift_phase(ub_s1, mx_s1, mn_s1, cfg);
	assign pc = shift_phase(uc_s1, mx_s1, mn_s1, cfg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= up_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && up_valid) begin
			ua_s1  <= u_a;
			ub_s1  <= u_b;
			uc_s1  <= u_c;
			mn_s1  <= mn_next;
			mx_s1  <= mx_next;
			rev_s1 <= rev_in;
		end
		if (adv_s2 && valid_s1) begin
			pa_s2 <= pa;
			pb_s2 <= rev_s1 ? pc : pb;
			pc_s2 <= rev_s1 ? pb : pc;
		end
	end

	assign dn_valid = valid_s2;
	assign phase_a  = pa_s2;
	assign phase_b  = pb_s2;
	assign phase_c  = pc_s2;

endmodule
`default_nettype wire

@@ rtl/core/foc_sine_pwm_phase_voltages.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// foc_sine_pwm_phase_voltages: sine PWM phase voltage generator
// Inverse Park and inverse Clarke of a d/q command, then a midpoint clamp or
// minimum shift of the three phases and an optional b/c swap.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | volt_q, volt_d, rotor_angle, reverse_dir
//   out     | out_valid / out_ready| phase_a, phase_b, phase_c
//   cfg     | APB psel/penable     | supply_limit (0x0), centered_mode (0x4)
//
// Eight register stages: index fold, table read, products, Park sums, Clarke
// scaling, Clarke rounding, min/max, offset. One request per cycle is
// sustained while out_ready stays high.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up and in_ready drops only when every stage holds an item.
// Reset clears the stage valid bits and loads the registers' reset values.
// ----------------------------------------------------------------------------
module foc_sine_pwm_phase_voltages #(
	parameter int unsigned SINE_TABLE_DEPTH = fspv_pkg::SINE_DEPTH_DEF,
	parameter int unsigned TRIG_FRAC_BITS   = fspv_pkg::TRIG_FRAC_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic        [fspv_pkg::PADDR_W-1:0] paddr,
	input  logic        [fspv_pkg::PDATA_W-1:0] pwdata,
	output logic        [fspv_pkg::PDATA_W-1:0] prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [fspv_pkg::VOLT_W-1:0]  volt_q,
	input  logic signed [fspv_pkg::VOLT_W-1:0]  volt_d,
	input  logic        [fspv_pkg::ANGLE_W-1:0] rotor_angle,
	input  logic                                reverse_dir,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [fspv_pkg::PHASE_W-1:0] phase_a,
	output logic signed [fspv_pkg::PHASE_W-1:0] phase_b,
	output logic signed [fspv_pkg::PHASE_W-1:0] phase_c
);
	import fspv_pkg::*;

	localparam int unsigned TRIG_W = TRIG_FRAC_BITS + 2;
	localparam int unsigned AB_W   = TRIG_FRAC_BITS + 19;

	cfg_t               cfg_q;
	logic               cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.supply_limit  <= LIMIT_RESET;
			cfg_q.centered_mode <= CENTERED_RESET;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_LIMIT: cfg_q.supply_limit  <= pwdata[LIMIT_W-1:0];
				REG_MODE:  cfg_q.centered_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_LIMIT: prdata = PDATA_W'(cfg_q.supply_limit);
			REG_MODE:  prdata = PDATA_W'(cfg_q.centered_mode);
			default:   prdata = '0;
		endcase
	end

	logic                     trig_valid, trig_ready;
	logic signed [TRIG_W-1:0] sin_val, cos_val;
	logic signed [VOLT_W-1:0] vq_t, vd_t;
	logic                     rev_t;
	logic                     park_valid, park_ready;
	logic signed [AB_W-1:0]   alpha, beta;
	logic                     rev_p;
	logic                     clk_valid, clk_ready;
	logic signed [U_W-1:0]    u_a, u_b, u_c;
	logic                     rev_c;

	fspv_trig #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.TRIG_FRAC_BITS  (TRIG_FRAC_BITS)
	) u_trig (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (in_valid),
		.up_ready   (in_ready),
		.volt_q     (volt_q),
		.volt_d     (volt_d),
		.rotor_angle(rotor_angle),
		.reverse_dir(reverse_dir),
		.dn_valid   (trig_valid),
		.dn_ready   (trig_ready),
		.sin_val    (sin_val),
		.cos_val    (cos_val),
		.vq_out     (vq_t),
		.vd_out     (vd_t),
		.rev_out    (rev_t)
	);

	fspv_park #(
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_park (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_valid(trig_valid),
		.up_ready(trig_ready),
		.sin_val (sin_val),
		.cos_val (cos_val),
		.volt_q  (vq_t),
		.volt_d  (vd_t),
		.rev_in  (rev_t),
		.dn_valid(park_valid),
		.dn_ready(park_ready),
		.alpha   (alpha),
		.beta    (beta),
		.rev_out (rev_p)
	);

	fspv_clarke #(
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_clarke (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_valid(park_valid),
		.up_ready(park_ready),
		.alpha   (alpha),
		.beta    (beta),
		.rev_in  (rev_p),
		.dn_valid(clk_valid),
		.dn_ready(clk_ready),
		.u_a     (u_a),
		.u_b     (u_b),
		.u_c     (u_c),
		.rev_out (rev_c)
	);

	fspv_offset u_offset (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.up_valid(clk_valid),
		.up_ready(clk_ready),
		.u_a     (u_a),
		.u_b     (u_b),
		.u_c     (u_c),
		.rev_in  (rev_c),
		.dn_valid(out_valid),
		.dn_ready(out_ready),
		.phase_a (phase_a),
		.phase_b (phase_b),
		.phase_c (phase_c)
	);

	// back-pressure only ever starts at a stalled output
	a_ready_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("in_ready low without a stalled result");

	// a free output lets every stage advance
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> (in_ready && trig_ready && park_ready && clk_ready))
		else $error("pipeline held while output is free");

	// nothing comes out of an empty pipeline straight after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid straight after reset");

endmodule
`default_nettype wire

@@ tb/foc_sine_pwm_phase_voltages_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foc_sine_pwm_phase_voltages_test: self-checking bench of the phase generator
// Drives d/q commands with angle and direction over valid/ready, predicts the
// three phase voltages from its own quarter-wave table and fixed-point
// inverse Park/Clarke, and compares every result in order. Runs a directed
// table, then random requests under several limit/mode register settings.
// ----------------------------------------------------------------------------
module foc_sine_pwm_phase_voltages_test;
	import fspv_pkg::*;

	localparam int unsigned SINE_D      = SINE_DEPTH_DEF;
	localparam int unsigned TRIG_BITS   = TRIG_FRAC_DEF;
	localparam int          HALF_PERIOD = 5;
	localparam int          CYCLE_LIMIT = 200000;
	localparam int          LONG_HOLD   = 300;
	localparam int          PHASES      = 7;
	localparam int          PER_PHASE   = 95;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1073741824;

	typedef struct packed {
		logic signed [PHASE_W-1:0] a;
		logic signed [PHASE_W-1:0] b;
		logic signed [PHASE_W-1:0] c;
	} phases_t;

	typedef struct packed {
		logic signed [VOLT_W-1:0]  vq;
		logic signed [VOLT_W-1:0]  vd;
		logic        [ANGLE_W-1:0] ang;
		logic                      rev;
		logic                      typed;
		phases_t                   res;
	} dir_row_t;

	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        psel        = 1'b0;
	logic                        penable     = 1'b0;
	logic                        pwrite      = 1'b0;
	logic        [PADDR_W-1:0]   paddr       = '0;
	logic        [PDATA_W-1:0]   pwdata      = '0;
	logic        [PDATA_W-1:0]   prdata;
	logic                        pready;
	logic                        in_valid    = 1'b0;
	logic                        in_ready;
	logic signed [VOLT_W-1:0]    volt_q      = '0;
	logic signed [VOLT_W-1:0]    volt_d      = '0;
	logic        [ANGLE_W-1:0]   rotor_angle = '0;
	logic                        reverse_dir = 1'b0;
	logic                        out_valid;
	logic                        out_ready   = 1'b0;
	logic signed [PHASE_W-1:0]   phase_a;
	logic signed [PHASE_W-1:0]   phase_b;
	logic signed [PHASE_W-1:0]   phase_c;

	// model of the register file
	logic [LIMIT_W-1:0] model_limit    = LIMIT_RESET;
	logic               model_centered = CENTERED_RESET;

	longint  quarter_sine [0:SINE_D];
	phases_t pending_phases [$];
	logic    use_typed = 1'b0;
	phases_t typed_value = '0;
	dir_row_t directed [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_reqs     = 0;
	int holds_done    = 0;
	int hold_left     = 0;
	int errors        = 0;
	int checked       = 0;
	int cycles        = 0;

	foc_sine_pwm_phase_voltages dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.volt_q      (volt_q),
		.volt_d      (volt_d),
		.rotor_angle (rotor_angle),
		.reverse_dir (reverse_dir),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.phase_a     (phase_a),
		.phase_b     (phase_b),
		.phase_c     (phase_c)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// odd Taylor polynomial of sin, Horner form, divisors (2n)(2n+1)
	function automatic longint sine_entry(int unsigned i);
		longint unsigned x, x2, t, s, e;
		x  = (HALF_PI_Q30 * i) / SINE_D;
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		for (int n = 6; n >= 1; n--)
			t = ONE_Q30 - ((x2 * t) >> 30) / (2 * n * (2 * n + 1));
		s = (x * t) >> 30;
		e = (s + (64'd1 << (29 - TRIG_BITS))) >> (30 - TRIG_BITS);
		if (e > (64'd1 << TRIG_BITS))
			e = 64'd1 << TRIG_BITS;
		return longint'(e);
	endfunction

	function automatic longint sine_at(logic [ANGLE_W-1:0] ang);
		int unsigned idx;
		longint v;
		idx = (ang[QUAD_FRAC_W-1:0] * SINE_D + 8192) >> QUAD_FRAC_W;
		v = ang[QUAD_FRAC_W] ? quarter_sine[SINE_D - idx] : quarter_sine[idx];
		return ang[QUAD_FRAC_W+1] ? -v : v;
	endfunction

	// floor((v + 2^(sh-1)) / 2^sh)
	function automatic longint shift_round(longint v, int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic phases_t predict_phases(logic signed [VOLT_W-1:0] vq_in,
			logic signed [VOLT_W-1:0] vd_in, logic [ANGLE_W-1:0] ang, logic rev);
		longint vq, vd, sn, cs, alpha, beta, mn, mx, vl, k3, tmp;
		longint u [3];
		phases_t res;
		vq    = longint'(vq_in);
		vd    = longint'(vd_in);
		vl    = longint'(model_limit);
		k3    = longint'(SQRT3_HALF_Q17);
		sn    = sine_at(ang);
		cs    = sine_at(ang + QUARTER_TURN);
		alpha = cs * vd - sn * vq;
		beta  = sn * vd + cs * vq;
		u[0]  = shift_round(alpha * 131072, TRIG_BITS + 17);
		u[1]  = shift_round(-alpha * 65536 + k3 * beta, TRIG_BITS + 17);
		u[2]  = shift_round(-alpha * 65536 - k3 * beta, TRIG_BITS + 17);
		mn = u[0];
		mx = u[0];
		for (int k = 1; k < 3; k++) begin
			if (u[k] < mn) mn = u[k];
			if (u[k] > mx) mx = u[k];
		end
		for (int k = 0; k < 3; k++) begin
			if (model_centered)
				u[k] = shift_round(2 * u[k] + vl - mx - mn, 1);
			else
				u[k] = u[k] - mn;
		end
		if (rev) begin
			tmp  = u[1];
			u[1] = u[2];
			u[2] = tmp;
		end
		res.a = u[0][PHASE_W-1:0];
		res.b = u[1][PHASE_W-1:0];
		res.c = u[2][PHASE_W-1:0];
		return res;
	endfunction

	function automatic dir_row_t dir_row(logic signed [VOLT_W-1:0] vq,
			logic signed [VOLT_W-1:0] vd, logic [ANGLE_W-1:0] ang, logic rev,
			logic typed, int a, int b, int c);
		dir_row_t r;
		r.vq    = vq;
		r.vd    = vd;
		r.ang   = ang;
		r.rev   = rev;
		r.typed = typed;
		r.res.a = PHASE_W'(a);
		r.res.b = PHASE_W'(b);
		r.res.c = PHASE_W'(c);
		return r;
	endfunction

	function automatic logic signed [VOLT_W-1:0] rand_volt();
		case ($urandom_range(5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return VOLT_W'($urandom_range(2047) - 1024);
			3: return '0;
			default: return VOLT_W'($urandom);
		endcase
	endfunction

	function automatic logic [ANGLE_W-1:0] rand_angle();
		case ($urandom_range(4))
			0: return {2'($urandom_range(3)), 14'h0000};
			1: return {2'($urandom_range(3)), 14'h3FFF};
			2: return {2'($urandom_range(3)), 14'($urandom_range(63))};
			default: return ANGLE_W'($urandom);
		endcase
	endfunction

	// offer one request; returns at the falling edge after it is taken
	task automatic offer(logic signed [VOLT_W-1:0] vq, logic signed [VOLT_W-1:0] vd,
			logic [ANGLE_W-1:0] ang, logic rev);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		volt_q      = vq;
		volt_d      = vd;
		rotor_angle = ang;
		reverse_dir = rev;
		in_valid    = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// upper data bits are junk on purpose: the block must ignore them
	task automatic write_reg(logic idx, logic [PDATA_W-1:0] val);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = $urandom;
		if (idx == REG_LIMIT)
			pwdata[LIMIT_W-1:0] = val[LIMIT_W-1:0];
		else
			pwdata[0] = val[0];
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		if (idx == REG_LIMIT)
			model_limit = val[LIMIT_W-1:0];
		else
			model_centered = val[0];
	endtask

	task automatic wait_drained();
		while (pending_phases.size() != 0) @(negedge clk);
	endtask

	// drained, then let the eight stages run dry
	task automatic settle();
		wait_drained();
		repeat (16) @(negedge clk);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else if (hold_reqs != holds_done) begin
			holds_done++;
			hold_left = LONG_HOLD;
			out_ready = 1'b0;
		end else begin
			out_ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d results outstanding", $time,
				pending_phases.size());
			$display("foc_sine_pwm_phase_voltages_test: errors");
			$finish;
		end
	end

	// record each taken request, check each delivered result
	always @(posedge clk) begin
		phases_t want;
		if (arst_n && in_valid && in_ready) begin
			if (use_typed)
				pending_phases.push_back(typed_value);
			else
				pending_phases.push_back(predict_phases(volt_q, volt_d, rotor_angle,
					reverse_dir));
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_phases.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: a=%0d b=%0d c=%0d",
					$time, phase_a, phase_b, phase_c);
			end else begin
				want = pending_phases.pop_front();
				checked++;
				if (phase_a !== want.a) begin
					errors++;
					$display("%0t: phase_a expected %0d got %0d", $time, want.a, phase_a);
				end
				if (phase_b !== want.b) begin
					errors++;
					$display("%0t: phase_b expected %0d got %0d", $time, want.b, phase_b);
				end
				if (phase_c !== want.c) begin
					errors++;
					$display("%0t: phase_c expected %0d got %0d", $time, want.c, phase_c);
				end
			end
		end
	end

	initial begin
		logic [LIMIT_W-1:0] lim;
		logic               mode;
		int                 settings;
		for (int i = 0; i <= SINE_D; i++)
			quarter_sine[i] = sine_entry(i);

		// zero command sits at half the limit; unit d-axis at zero angle is
		// alpha = 1 V, so a = 1024, b = c = -512 before the midpoint clamp
		directed.push_back(dir_row(16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b1, 6144, 6144, 6144));
		directed.push_back(dir_row(16'sd0, 16'sd0, 16'h9000, 1'b1, 1'b1, 6144, 6144, 6144));
		directed.push_back(dir_row(16'sd0, 16'sd1024, 16'h0000, 1'b0, 1'b1, 6912, 5376, 5376));
		directed.push_back(dir_row(16'sh7FFF, 16'sd0, 16'h0000, 1'b0, 1'b0, 0, 0, 0));
		directed.push_back(dir_row(16'sh8000, 16'sd0, 16'h0000, 1'b0, 1'b0, 0, 0, 0));
		directed.push_back(dir_row(16'sd0, 16'sh7FFF, 16'h4000, 1'b0, 1'b0, 0, 0, 0));
		directed.push_back(dir_row(16'sd0, 16'sh8000, 16'h8000, 1'b0, 1'b0, 0, 0, 0));
		directed.push_back(dir_row(16'sh7FFF, 16'sh7FFF, 16'hC000, 1'b0, 1'b0, 0, 0, 0));
		directed.push_back(dir_row(16'sh8000, 16'sh8000, 16'hFFFF, 1'b1, 1'b0, 0, 0, 0));
		directed.push_back(dir_row(16'sh7FFF, 16'sh8000, 16'h2000, 1'b0, 1'b0, 0, 0, 0));
		directed.push_back(dir_row(16'sh8000, 16'sh7FFF, 16'h3FFF, 1'b1, 1'b0, 0, 0, 0));
		directed.push_back(dir_row(16'sd1000, -16'sd2000, 16'h0020, 1'b0, 1'b0, 0, 0, 0));
		directed.push_back(dir_row(16'sd5000, 16'sd5000, 16'h7FE0, 1'b1, 1'b0, 0, 0, 0));
		directed.push_back(dir_row(-16'sd1, -16'sd1, 16'h5555, 1'b0, 1'b0, 0, 0, 0));
		directed.push_back(dir_row(16'sh5555, 16'shAAAA, 16'hAAAA, 1'b1, 1'b0, 0, 0, 0));
		directed.push_back(dir_row(16'shAAAA, 16'sh5555, 16'h5555, 1'b0, 1'b0, 0, 0, 0));
		directed.push_back(dir_row(16'sd12000, 16'sd0, 16'hBFFF, 1'b1, 1'b0, 0, 0, 0));
		directed.push_back(dir_row(16'sd0, 16'sd12000, 16'h4001, 1'b0, 1'b0, 0, 0, 0));
		directed.push_back(dir_row(-16'sd7000, 16'sd3000, 16'hE000, 1'b1, 1'b0, 0, 0, 0));
		directed.push_back(dir_row(16'sd1, 16'sd0, 16'h0000, 1'b0, 1'b0, 0, 0, 0));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 30;
		recv_idle_pct = 83;
		foreach (directed[i]) begin
			use_typed   = directed[i].typed;
			typed_value = directed[i].res;
			offer(directed[i].vq, directed[i].vd, directed[i].ang, directed[i].rev);
		end
		use_typed = 1'b0;

		settings = 1;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin lim = '0;                     mode = 1'b1; end
				1: begin lim = '1;                     mode = 1'b1; end
				2: begin lim = '0;                     mode = 1'b0; end
				3: begin lim = '1;                     mode = 1'b0; end
				4: begin lim = LIMIT_W'($urandom);     mode = 1'b1; end
				5: begin lim = LIMIT_W'($urandom);     mode = 1'b0; end
				default: begin lim = LIMIT_W'($urandom); mode = 1'($urandom); end
			endcase
			// registers change only with the pipe empty
			in_valid = 1'b0;
			settle();
			write_reg(REG_LIMIT, PDATA_W'(lim));
			write_reg(REG_MODE, PDATA_W'(mode));
			settings++;

			if (ph < 2) begin
				send_idle_pct = 30;
				recv_idle_pct = 83;
			end else if (ph < 4) begin
				send_idle_pct = 83;
				recv_idle_pct = 30;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// hold the output off while requests keep coming, so the pipe fills
			if (ph == 4)
				hold_reqs++;

			for (int n = 0; n < PER_PHASE; n++) begin
				if (ph == 2 && n == PER_PHASE / 2) begin
					in_valid = 1'b0;
					wait_drained();
				end
				offer(rand_volt(), rand_volt(), rand_angle(), 1'($urandom));
			end
		end

		in_valid = 1'b0;
		settle();

		$display("%0d results checked across %0d limit/mode settings, both offset modes,",
			checked, settings);
		$display("limit at 0 and full scale, stalls on either side and a full-pipe hold-off");
		if (errors == 0)
			$display("foc_sine_pwm_phase_voltages_test: clean");
		else
			$display("foc_sine_pwm_phase_voltages_test: errors");
		$finish;
	end

endmodule
